// ===== hw/rtl/cdfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdfd_pkg
// Shared types and constants of the serial CAN dongle frame deframer.
// ----------------------------------------------------------------------------
package cdfd_pkg;

    // start bytes seen while hunting
    localparam logic [7:0]  START_CAN     = 8'h43;  // 'C'
    localparam logic [7:0]  START_ERR     = 8'h45;  // 'E'

    // error reports always carry four bytes
    localparam logic [3:0]  ERR_LEN       = 4'd4;

    // reset value of the timeout limit register
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_HDR2  = 3'd2,
        PH_CDATA = 3'd3,
        PH_EDATA = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_NOPAY   = 2'd1,
        ST_ERRREP  = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    // one input request
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
    } t_item;

    // one result request
    typedef struct packed {
        t_status     status;
        logic [10:0] ident;
        logic [3:0]  length;
        logic        rtr;
        logic [7:0]  data_byte;
        logic [3:0]  byte_index;
        logic        last;
    } t_result;

endpackage

// ===== hw/rtl/cdfd_core.sv =====
// ----------------------------------------------------------------------------
// cdfd_core
// Frame phase machine, one pass per item: hunts start bytes, counts empty ticks,
// parses headers, emits a result per payload byte, no-payload header or timeout.
// ----------------------------------------------------------------------------
module cdfd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  cdfd_pkg::t_item    i_item,
    input  logic [15:0]        i_timeout_limit,
    output logic               o_res_valid,
    output cdfd_pkg::t_result  o_res
);

    cdfd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_miss_count, n_miss_count;
    logic [7:0]  r_ident_high, n_ident_high;
    logic [10:0] r_frame_ident, n_frame_ident;
    logic [3:0]  r_frame_length, n_frame_length;
    logic        r_frame_rtr, n_frame_rtr;
    logic [3:0]  r_payload_count, n_payload_count;

    // shared decode
    logic [16:0] w_miss_inc;
    logic        w_miss_hit;
    logic        w_limit_zero;
    logic [10:0] w_hdr_ident;
    logic [3:0]  w_hdr_len;
    logic        w_hdr_rtr;
    logic        w_hdr_nopay;
    logic [4:0]  w_idx_inc;
    logic        w_cdata_last;
    logic        w_edata_last;
    logic [7:0]  w_b;

    assign w_b          = i_item.rx_byte;
    assign w_limit_zero = (i_timeout_limit == 16'd0);
    assign w_miss_inc   = {1'b0, r_miss_count} + 17'd1;
    assign w_miss_hit   = (w_miss_inc >= {1'b0, i_timeout_limit});
    assign w_hdr_ident  = {r_ident_high, w_b[7:5]};
    assign w_hdr_len    = w_b[3:0];
    assign w_hdr_rtr    = w_b[4];
    assign w_hdr_nopay  = w_hdr_rtr || (w_hdr_len == 4'd0);
    assign w_idx_inc    = {1'b0, r_payload_count} + 5'd1;
    assign w_cdata_last = (w_idx_inc >= {1'b0, r_frame_length});
    assign w_edata_last = (w_idx_inc >= {1'b0, cdfd_pkg::ERR_LEN});

    // next state
    always_comb begin
        n_phase         = r_phase;
        n_miss_count    = r_miss_count;
        n_ident_high    = r_ident_high;
        n_frame_ident   = r_frame_ident;
        n_frame_length  = r_frame_length;
        n_frame_rtr     = r_frame_rtr;
        n_payload_count = r_payload_count;
        if (i_step) begin
            case (r_phase)
                cdfd_pkg::PH_HDR1: begin
                    if (i_item.byte_valid) begin
                        n_ident_high = w_b;
                        n_phase      = cdfd_pkg::PH_HDR2;
                    end
                end
                cdfd_pkg::PH_HDR2: begin
                    if (i_item.byte_valid) begin
                        n_frame_ident   = w_hdr_ident;
                        n_frame_length  = w_hdr_len;
                        n_frame_rtr     = w_hdr_rtr;
                        n_payload_count = 4'd0;
                        n_phase = w_hdr_nopay ? cdfd_pkg::PH_HUNT : cdfd_pkg::PH_CDATA;
                    end
                end
                cdfd_pkg::PH_CDATA: begin
                    if (i_item.byte_valid) begin
                        if (w_cdata_last) begin
                            n_payload_count = 4'd0;
                            n_phase         = cdfd_pkg::PH_HUNT;
                        end else begin
                            n_payload_count = w_idx_inc[3:0];
                        end
                    end
                end
                cdfd_pkg::PH_EDATA: begin
                    if (i_item.byte_valid) begin
                        if (w_edata_last) begin
                            n_payload_count = 4'd0;
                            n_phase         = cdfd_pkg::PH_HUNT;
                        end else begin
                            n_payload_count = w_idx_inc[3:0];
                        end
                    end
                end
                default: begin
                    // hunting, also any stray phase code
                    n_phase = cdfd_pkg::PH_HUNT;
                    if (w_limit_zero) begin
                        n_miss_count = 16'd0;
                    end else if (!i_item.byte_valid) begin
                        n_miss_count = w_miss_hit ? 16'd0 : w_miss_inc[15:0];
                    end else if (w_b == cdfd_pkg::START_CAN) begin
                        n_miss_count = 16'd0;
                        n_phase      = cdfd_pkg::PH_HDR1;
                    end else if (w_b == cdfd_pkg::START_ERR) begin
                        n_miss_count    = 16'd0;
                        n_frame_ident   = 11'd0;
                        n_frame_length  = cdfd_pkg::ERR_LEN;
                        n_frame_rtr     = 1'b0;
                        n_payload_count = 4'd0;
                        n_phase         = cdfd_pkg::PH_EDATA;
                    end
                end
            endcase
        end
    end

    // result for the current item
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            cdfd_pkg::PH_HDR1: begin
                o_res_valid = 1'b0;
            end
            cdfd_pkg::PH_HDR2: begin
                if (i_item.byte_valid && w_hdr_nopay) begin
                    o_res_valid  = 1'b1;
                    o_res.status = cdfd_pkg::ST_NOPAY;
                    o_res.ident  = w_hdr_ident;
                    o_res.length = w_hdr_len;
                    o_res.rtr    = w_hdr_rtr;
                    o_res.last   = 1'b1;
                end
            end
            cdfd_pkg::PH_CDATA: begin
                if (i_item.byte_valid) begin
                    o_res_valid      = 1'b1;
                    o_res.status     = cdfd_pkg::ST_DATA;
                    o_res.ident      = r_frame_ident;
                    o_res.length     = r_frame_length;
                    o_res.data_byte  = w_b;
                    o_res.byte_index = r_payload_count;
                    o_res.last       = w_cdata_last;
                end
            end
            cdfd_pkg::PH_EDATA: begin
                if (i_item.byte_valid) begin
                    o_res_valid      = 1'b1;
                    o_res.status     = cdfd_pkg::ST_ERRREP;
                    o_res.length     = cdfd_pkg::ERR_LEN;
                    o_res.data_byte  = w_b;
                    o_res.byte_index = r_payload_count;
                    o_res.last       = w_edata_last;
                end
            end
            default: begin
                // timeout on zero limit, or when the tick count reaches the limit
                if (w_limit_zero || (!i_item.byte_valid && w_miss_hit)) begin
                    o_res_valid  = 1'b1;
                    o_res.status = cdfd_pkg::ST_TIMEOUT;
                    o_res.last   = 1'b1;
                end
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= cdfd_pkg::PH_HUNT;
            r_miss_count    <= 16'd0;
            r_ident_high    <= 8'd0;
            r_frame_ident   <= 11'd0;
            r_frame_length  <= 4'd0;
            r_frame_rtr     <= 1'b0;
            r_payload_count <= 4'd0;
        end else begin
            r_phase         <= n_phase;
            r_miss_count    <= n_miss_count;
            r_ident_high    <= n_ident_high;
            r_frame_ident   <= n_frame_ident;
            r_frame_length  <= n_frame_length;
            r_frame_rtr     <= n_frame_rtr;
            r_payload_count <= n_payload_count;
        end
    end

endmodule

// ===== hw/rtl/can_dongle_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// can_dongle_frame_deframer_unit
// Receive-side deframer for a serial CAN dongle byte stream.
// ----------------------------------------------------------------------------
// The block takes one request per clock (a byte or an empty read tick) and
// gives at most one result per request. A request is held in the input
// register, where the phase machine handles it in a single pass, and its
// result is loaded into the output register as the request leaves it.
// Throughput is one request per cycle while the output side keeps taking
// results; a stall on the output holds the result register and then the
// input register. The timeout limit register is written through the cfg
// channel, which is always ready, and should be changed only while no
// request is in flight.
module can_dongle_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [10:0] o_ident,
    output logic [3:0]  o_length,
    output logic        o_rtr,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_byte_index,
    output logic        o_last
);

    logic [15:0]       r_timeout_limit;
    logic              r_in_vld;
    cdfd_pkg::t_item   r_in;
    logic              r_out_vld;
    cdfd_pkg::t_result r_out;

    logic              w_advance;
    logic              w_step;
    logic              w_res_valid;
    cdfd_pkg::t_result w_res;

    // flow control: result register moves unless held, input follows it
    assign w_advance  = !(r_out_vld && i_out_stall);
    assign w_step     = r_in_vld && w_advance;
    assign o_in_stall = r_in_vld && !w_advance;
    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= cdfd_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout_limit <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_vld <= 1'b1;
        end else if (w_step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in.byte_valid <= i_byte_valid;
            r_in.rx_byte    <= i_rx_byte;
        end
    end

    cdfd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_item          (r_in),
        .i_timeout_limit (r_timeout_limit),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= w_step && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_out.status;
    assign o_ident      = r_out.ident;
    assign o_length     = r_out.length;
    assign o_rtr        = r_out.rtr;
    assign o_data_byte  = r_out.data_byte;
    assign o_byte_index = r_out.byte_index;
    assign o_last       = r_out.last;

    // checks
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld))
        else $error("input stalled without a held item");

    a_timeout_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == cdfd_pkg::ST_TIMEOUT) |->
            (o_last && o_ident == 11'd0 && o_length == 4'd0))
        else $error("malformed timeout result");

    a_errrep_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == cdfd_pkg::ST_ERRREP) |->
            (o_length == cdfd_pkg::ERR_LEN && o_ident == 11'd0 && !o_rtr))
        else $error("malformed error report result");

    a_nopay_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == cdfd_pkg::ST_NOPAY) |->
            (o_last && o_byte_index == 4'd0 && o_data_byte == 8'd0))
        else $error("malformed no-payload result");

endmodule
